### rtl/hpts_pkg.sv
// ----------------------------------------------------------------------------
// hpts_pkg
// Types and constants shared by the haptic pulse train scheduler files.
// ----------------------------------------------------------------------------
package hpts_pkg;

	// item kinds on the request channel
	localparam logic MODE_CMD  = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	// register indexes on the configuration port
	localparam logic REG_ENABLE   = 1'b0;
	localparam logic REG_STRENGTH = 1'b1;

	// timing and scaling constants
	localparam logic [15:0] DEFAULT_ON_MS = 16'd30;
	localparam logic [6:0]  FULL_PERCENT  = 7'd100;
	// floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for x <= 255 * 100
	localparam logic [12:0] RECIP_100     = 13'd5243;
	localparam int          RECIP_SHIFT   = 19;
	localparam int          SCALE_W       = 20;
	localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(100 * 5243);

	// amplitude byte lanes inside a stored amplitude word
	localparam logic [1:0] LANE_LEFT_LOW   = 2'd0;
	localparam logic [1:0] LANE_RIGHT_LOW  = 2'd1;
	localparam logic [1:0] LANE_LEFT_HIGH  = 2'd2;
	localparam logic [1:0] LANE_RIGHT_HIGH = 2'd3;

	typedef struct packed {
		logic        mode;
		logic [2:0]  pad_index;
		logic [7:0]  left_low_amp;
		logic [7:0]  right_low_amp;
		logic [7:0]  left_high_amp;
		logic [7:0]  right_high_amp;
		logic [15:0] on_time_ms;
		logic [15:0] off_delay_ms;
		logic [7:0]  repeat_count;
	} req_t;

	typedef struct packed {
		logic [2:0] channel;
		logic       drive_on;
		logic [7:0] out_left_low;
		logic [7:0] out_left_high;
		logic [7:0] out_right_low;
		logic [7:0] out_right_high;
		logic       last_of_tick;
	} drive_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_ADV,
		ST_SCALE,
		ST_PUSH,
		ST_FLUSH
	} state_t;

endpackage

### rtl/hpts_chan_if.sv
// ----------------------------------------------------------------------------
// hpts_chan_if
// Valid/ready channel carrying one payload word per handshake.
// ----------------------------------------------------------------------------
interface hpts_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

### rtl/haptic_pulse_train_scheduler_unit.sv
// ----------------------------------------------------------------------------
// haptic_pulse_train_scheduler_unit
// Per-channel vibration pulse trains, walked once per millisecond tick.
// ----------------------------------------------------------------------------
// A command word loads one channel in the cycle it is taken. A tick word
// starts a walk over the channels: each channel passes through a timer
// check state and an update state, and a channel that emits a drive word
// then scales its four amplitudes in turn through the single shared 8x20
// scaling multiplier and hands the word on. The last word of a tick is held
// back in a pending register so it can carry last_of_tick; the walk ends
// in a flush state. The walk waits whenever the drive channel stalls. No
// new word is taken during a walk. Strength writes recompute the scale
// factor in the write cycle.
// ----------------------------------------------------------------------------
module haptic_pulse_train_scheduler_unit
	import hpts_pkg::*;
#(
	parameter int NUM_CHANNELS = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	hpts_chan_if.sink          req,
	hpts_chan_if.source        drive,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	// configuration registers
	logic               enable_q;
	logic [6:0]         strength_q;
	logic [SCALE_W-1:0] scale_q;

	// per-channel stores
	logic [31:0] amp_mem   [NUM_CHANNELS];
	logic [15:0] on_mem    [NUM_CHANNELS];
	logic [15:0] off_mem   [NUM_CHANNELS];
	logic [7:0]  rep_mem   [NUM_CHANNELS];
	logic [16:0] pos_mem   [NUM_CHANNELS];
	logic [8:0]  done_mem  [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] active_q;
	logic [NUM_CHANNELS-1:0] on_flag_q;
	logic [NUM_CHANNELS-1:0] dirty_q;

	// sequencer
	state_t      state_q, state_d;
	logic [CH_W-1:0] idx_q;
	logic [1:0]  lane_q;
	logic        want_q;
	logic        adv_q;
	logic        fin_q;
	logic [16:0] pos_inc_q;
	drive_t      build_q;
	drive_t      pend_q;
	logic        pend_v_q;
	drive_t      out_q;
	logic        out_v_q;

	// request decode
	req_t        rq;
	logic        req_fire;
	logic        cmd_fire;
	logic        pad_ok;
	logic [CH_W-1:0] pad_idx;
	logic        amp_nz;

	// channel read and timer math
	logic [31:0] amp_rd;
	logic [15:0] on_rd;
	logic [15:0] off_rd;
	logic [7:0]  rep_rd;
	logic [16:0] pos_rd;
	logic [8:0]  done_rd;
	logic [15:0] on_eff;
	logic [16:0] cyc_len;
	logic        wrap;
	logic        emit;
	logic        last_ch;
	logic        out_free;
	logic        slot_ok;

	// shared scaling unit
	logic [7:0]         lane_amp;
	logic [SCALE_W+7:0] lane_prod;
	logic [7:0]         lane_res;

	// config port
	logic        cfg_wr;
	logic [6:0]  wr_pct;
	logic [6:0]  wr_sat;
	logic [SCALE_W-1:0] wr_scale;

	assign rq       = req.payload;
	assign req_fire = req.valid && req.ready;
	assign cmd_fire = req_fire && (rq.mode == MODE_CMD);
	assign pad_ok   = {1'b0, rq.pad_index} < 4'(NUM_CHANNELS);
	assign pad_idx  = rq.pad_index[CH_W-1:0];
	assign amp_nz   = |{rq.left_low_amp, rq.right_low_amp, rq.left_high_amp,
		rq.right_high_amp};

	assign amp_rd  = amp_mem[idx_q];
	assign on_rd   = on_mem[idx_q];
	assign off_rd  = off_mem[idx_q];
	assign rep_rd  = rep_mem[idx_q];
	assign pos_rd  = pos_mem[idx_q];
	assign done_rd = done_mem[idx_q];

	assign on_eff   = (on_rd != 16'd0) ? on_rd : DEFAULT_ON_MS;
	assign cyc_len  = {1'b0, off_rd} + {1'b0, on_eff};
	assign wrap     = pos_inc_q >= cyc_len;
	assign emit     = (want_q != on_flag_q[idx_q]) || (want_q && dirty_q[idx_q]);
	assign last_ch  = idx_q == CH_W'(NUM_CHANNELS - 1);
	assign out_free = !out_v_q || drive.ready;
	assign slot_ok  = !pend_v_q || out_free;

	// one amplitude lane per cycle through the multiplier
	assign lane_amp  = amp_rd[{lane_q, 3'b000} +: 8];
	assign lane_prod = {{SCALE_W{1'b0}}, lane_amp} * {8'd0, scale_q};
	assign lane_res  = build_q.drive_on ? lane_prod[RECIP_SHIFT +: 8] : 8'd0;

	// config write decode
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign wr_pct   = pwdata[6:0];
	assign wr_sat   = (wr_pct > FULL_PERCENT) ? FULL_PERCENT : wr_pct;
	assign wr_scale = SCALE_W'(wr_sat) * SCALE_W'(RECIP_100);

	assign pready = 1'b1;

	// register readback
	always_comb begin
		case (paddr[2])
			REG_ENABLE:   prdata = {31'd0, enable_q};
			REG_STRENGTH: prdata = {25'd0, strength_q};
			default:      prdata = 32'd0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_fire && (rq.mode == MODE_TICK)) state_d = ST_EVAL;
			end
			ST_EVAL: state_d = ST_ADV;
			ST_ADV: begin
				if (emit) state_d = ST_SCALE;
				else if (last_ch) state_d = ST_FLUSH;
				else state_d = ST_EVAL;
			end
			ST_SCALE: begin
				if (lane_q == LANE_RIGHT_HIGH) state_d = ST_PUSH;
			end
			ST_PUSH: begin
				if (slot_ok) state_d = last_ch ? ST_FLUSH : ST_EVAL;
			end
			ST_FLUSH: begin
				if (slot_ok) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// channel outputs
	always_comb begin
		req.ready     = (state_q == ST_IDLE);
		drive.valid   = out_v_q;
		drive.payload = out_q;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= 1'b1;
			strength_q <= FULL_PERCENT;
			scale_q    <= SCALE_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_ENABLE:   enable_q <= pwdata[0];
				REG_STRENGTH: begin
					strength_q <= wr_pct;
					scale_q    <= wr_scale;
				end
				default: ;
			endcase
		end
	end

	// control state and channel flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			lane_q    <= '0;
			active_q  <= '0;
			on_flag_q <= '0;
			dirty_q   <= '0;
			pend_v_q  <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			state_q <= state_d;

			// flag changes from config writes
			if (cfg_wr && (paddr[2] == REG_ENABLE) && enable_q && !pwdata[0]) begin
				active_q <= '0;
				dirty_q  <= '0;
			end
			if (cfg_wr && (paddr[2] == REG_STRENGTH)) begin
				dirty_q <= dirty_q | active_q;
			end

			// command load
			if (cmd_fire && pad_ok) begin
				active_q[pad_idx] <= enable_q && amp_nz;
				dirty_q[pad_idx]  <= 1'b1;
			end

			if (req_fire && (rq.mode == MODE_TICK)) idx_q <= '0;

			// word leaves the output register
			if (out_v_q && drive.ready) out_v_q <= 1'b0;

			case (state_q)
				ST_ADV: begin
					if (fin_q) active_q[idx_q] <= 1'b0;
					dirty_q[idx_q] <= 1'b0;
					if (emit) on_flag_q[idx_q] <= want_q;
					lane_q <= LANE_LEFT_LOW;
					if (!emit && !last_ch) idx_q <= idx_q + CH_W'(1);
				end
				ST_SCALE: lane_q <= lane_q + 2'd1;
				ST_PUSH: begin
					if (slot_ok) begin
						if (pend_v_q) out_v_q <= 1'b1;
						pend_v_q <= 1'b1;
						if (!last_ch) idx_q <= idx_q + CH_W'(1);
					end
				end
				ST_FLUSH: begin
					if (slot_ok && pend_v_q) begin
						out_v_q  <= 1'b1;
						pend_v_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// channel stores, timers and word payloads
	always_ff @(posedge clk) begin
		if (cmd_fire && pad_ok) begin
			amp_mem[pad_idx]  <= {rq.right_high_amp, rq.left_high_amp,
				rq.right_low_amp, rq.left_low_amp};
			on_mem[pad_idx]   <= rq.on_time_ms;
			off_mem[pad_idx]  <= rq.off_delay_ms;
			rep_mem[pad_idx]  <= rq.repeat_count;
			pos_mem[pad_idx]  <= '0;
			done_mem[pad_idx] <= '0;
		end

		case (state_q)
			// phase check at the current elapsed time
			ST_EVAL: begin
				adv_q     <= enable_q && active_q[idx_q] &&
					(done_rd < ({1'b0, rep_rd} + 9'd1));
				fin_q     <= enable_q && active_q[idx_q] &&
					(done_rd >= ({1'b0, rep_rd} + 9'd1));
				want_q    <= enable_q && active_q[idx_q] &&
					(done_rd < ({1'b0, rep_rd} + 9'd1)) && (pos_rd >= {1'b0, off_rd});
				pos_inc_q <= pos_rd + 17'd1;
			end
			// advance by one millisecond
			ST_ADV: begin
				if (adv_q) begin
					if (wrap) begin
						pos_mem[idx_q]  <= '0;
						done_mem[idx_q] <= done_rd + 9'd1;
					end else begin
						pos_mem[idx_q] <= pos_inc_q;
					end
				end
				build_q.channel        <= 3'(idx_q);
				build_q.drive_on       <= want_q;
				build_q.last_of_tick   <= 1'b0;
			end
			// scale one amplitude lane
			ST_SCALE: begin
				case (lane_q)
					LANE_LEFT_LOW:   build_q.out_left_low   <= lane_res;
					LANE_RIGHT_LOW:  build_q.out_right_low  <= lane_res;
					LANE_LEFT_HIGH:  build_q.out_left_high  <= lane_res;
					LANE_RIGHT_HIGH: build_q.out_right_high <= lane_res;
					default: ;
				endcase
			end
			// held word goes out, new word is held
			ST_PUSH: begin
				if (slot_ok) begin
					if (pend_v_q) out_q <= pend_q;
					pend_q <= build_q;
				end
			end
			// final word of the tick, last flag sits in the low bit
			ST_FLUSH: begin
				if (slot_ok && pend_v_q) begin
					out_q <= {pend_q[$bits(drive_t)-1:1], 1'b1};
				end
			end
			default: ;
		endcase
	end

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the haptic pulse train scheduler. Command and tick
// words go in over the request channel with random gaps, and drive words are
// taken with random stalls. A behavioral model of the per-channel pulse trains
// works out the drive words of every tick, which are checked field by field
// in order. Enable and strength settings change between phases while the
// block is idle.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import hpts_pkg::*;

	localparam int NCH           = 4;
	localparam int GAP_MAX       = 16;
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT   = 400000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	hpts_chan_if #(.payload_t(req_t))   req_if ();
	hpts_chan_if #(.payload_t(drive_t)) drive_if ();

	haptic_pulse_train_scheduler_unit #(
		.NUM_CHANNELS(NCH)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_if),
		.drive   (drive_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// clock
	always #6 clk = ~clk;

	// channel model state
	logic [31:0] ch_amp    [NCH];
	logic [15:0] ch_on_ms  [NCH];
	logic [15:0] ch_off_ms [NCH];
	logic [7:0]  ch_repeat [NCH];
	int          ch_pos    [NCH];
	int          ch_done   [NCH];
	bit          ch_active [NCH];
	bit          ch_lit    [NCH];
	bit          ch_dirty  [NCH];
	bit          en_reg;
	logic [6:0]  pct_reg;

	req_t        req_words_q[$];
	drive_t      drive_words_q[$];
	int          req_queued;
	int          req_taken;
	int          req_gap;
	int          drive_stall;
	int          err_cnt;
	int unsigned cycle_cnt;

	task automatic report(string what);
		$display("[%0t] mismatch: %s", $time, what);
		err_cnt++;
	endtask

	function automatic int draw_idle();
		if ($urandom_range(0, 2) != 0)
			return 0;
		return $urandom_range(0, GAP_MAX);
	endfunction

	// amplitude scaled by the strength setting, saturated at full scale
	function automatic logic [7:0] scaled(logic [7:0] a);
		int p;
		p = (pct_reg > FULL_PERCENT) ? int'(FULL_PERCENT) : int'(pct_reg);
		return 8'((int'(a) * p) / int'(FULL_PERCENT));
	endfunction

	function automatic void apply_reg_write(logic idx, logic [31:0] val);
		if (idx == REG_ENABLE) begin
			// falling enable drops every train, lit outputs go off at next tick
			if (en_reg && !val[0]) begin
				for (int ch = 0; ch < NCH; ch++) begin
					ch_active[ch] = 1'b0;
					ch_dirty[ch]  = 1'b0;
				end
			end
			en_reg = val[0];
		end else begin
			pct_reg = val[6:0];
			for (int ch = 0; ch < NCH; ch++)
				if (ch_active[ch])
					ch_dirty[ch] = 1'b1;
		end
	endfunction

	// load a channel on a command, or walk all channels on a tick
	function automatic void compute_drive_words(req_t it);
		drive_t w;
		drive_t held;
		bit     have_held;
		bit     want;
		int     len;
		have_held = 1'b0;
		if (it.mode == MODE_CMD) begin
			if (it.pad_index < NCH) begin
				ch_amp[it.pad_index]    = {it.right_high_amp, it.left_high_amp,
					it.right_low_amp, it.left_low_amp};
				ch_on_ms[it.pad_index]  = it.on_time_ms;
				ch_off_ms[it.pad_index] = it.off_delay_ms;
				ch_repeat[it.pad_index] = it.repeat_count;
				ch_pos[it.pad_index]    = 0;
				ch_done[it.pad_index]   = 0;
				ch_active[it.pad_index] = en_reg && ({it.right_high_amp, it.left_high_amp,
					it.right_low_amp, it.left_low_amp} != 32'h0);
				ch_dirty[it.pad_index]  = 1'b1;
			end
			return;
		end
		for (int ch = 0; ch < NCH; ch++) begin
			want = 1'b0;
			if (en_reg && ch_active[ch]) begin
				if (ch_done[ch] >= int'(ch_repeat[ch]) + 1) begin
					ch_active[ch] = 1'b0;
				end else begin
					len = int'(ch_off_ms[ch]) +
						((ch_on_ms[ch] != 16'h0) ? int'(ch_on_ms[ch]) : int'(DEFAULT_ON_MS));
					want = ch_pos[ch] >= int'(ch_off_ms[ch]);
					ch_pos[ch]++;
					if (ch_pos[ch] >= len) begin
						ch_pos[ch]  = 0;
						ch_done[ch] = (ch_done[ch] + 1) & 'h1FF;
					end
				end
			end
			// word on a switch, or a refresh while on and dirty
			if (want != ch_lit[ch] || (want && ch_dirty[ch])) begin
				w.channel        = 3'(ch);
				w.drive_on       = want;
				w.out_left_low   = want ? scaled(ch_amp[ch][7:0])   : 8'h0;
				w.out_right_low  = want ? scaled(ch_amp[ch][15:8])  : 8'h0;
				w.out_left_high  = want ? scaled(ch_amp[ch][23:16]) : 8'h0;
				w.out_right_high = want ? scaled(ch_amp[ch][31:24]) : 8'h0;
				w.last_of_tick   = 1'b0;
				if (have_held)
					drive_words_q.push_back(held);
				held      = w;
				have_held = 1'b1;
				ch_lit[ch] = want;
			end
			ch_dirty[ch] = 1'b0;
		end
		// final word of the tick carries the last flag
		if (have_held) begin
			held.last_of_tick = 1'b1;
			drive_words_q.push_back(held);
		end
	endfunction

	function automatic req_t make_cmd(logic [2:0] pad, logic [7:0] ll, logic [7:0] rl,
		logic [7:0] lh, logic [7:0] rh, logic [15:0] on_ms, logic [15:0] off_ms,
		logic [7:0] rep);
		req_t it;
		it.mode           = MODE_CMD;
		it.pad_index      = pad;
		it.left_low_amp   = ll;
		it.right_low_amp  = rl;
		it.left_high_amp  = lh;
		it.right_high_amp = rh;
		it.on_time_ms     = on_ms;
		it.off_delay_ms   = off_ms;
		it.repeat_count   = rep;
		return it;
	endfunction

	// mostly ticks; commands favor short trains so they finish within the run
	function automatic req_t random_item();
		req_t it;
		int   pick;
		it.mode           = MODE_TICK;
		it.pad_index      = 3'($urandom);
		it.left_low_amp   = 8'($urandom);
		it.right_low_amp  = 8'($urandom);
		it.left_high_amp  = 8'($urandom);
		it.right_high_amp = 8'($urandom);
		it.on_time_ms     = 16'($urandom);
		it.off_delay_ms   = 16'($urandom);
		it.repeat_count   = 8'($urandom);
		if ($urandom_range(0, 3) == 0) begin
			it.mode = MODE_CMD;
			it.pad_index = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(4, 7)) :
				3'($urandom_range(0, 3));
			pick = $urandom_range(0, 9);
			if (pick == 0)
				{it.left_low_amp, it.right_low_amp, it.left_high_amp, it.right_high_amp} = 32'h0;
			else if (pick == 1)
				{it.left_low_amp, it.right_low_amp, it.left_high_amp, it.right_high_amp} =
					32'hFFFF_FFFF;
			if ($urandom_range(0, 5) != 0) begin
				it.on_time_ms   = 16'($urandom_range(0, 5));
				it.off_delay_ms = 16'($urandom_range(0, 4));
			end
			if ($urandom_range(0, 7) != 0)
				it.repeat_count = 8'($urandom_range(0, 3));
		end
		return it;
	endfunction

	task automatic push_item(req_t it);
		req_words_q.push_back(it);
		req_queued++;
	endtask

	task automatic push_ticks(int n);
		req_t it;
		for (int i = 0; i < n; i++) begin
			it      = random_item();
			it.mode = MODE_TICK;
			push_item(it);
		end
	endtask

	task automatic push_random(int n);
		for (int i = 0; i < n; i++)
			push_item(random_item());
	endtask

	// hold the sender until every word is taken and every drive word is in
	task automatic settle();
		while (req_taken != req_queued || drive_words_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// setup then access cycle, written on the access edge
	task automatic reg_write(logic idx, logic [31:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		apply_reg_write(idx, val);
	endtask

	task automatic check_field(string name, logic [7:0] got, logic [7:0] exp);
		if (got !== exp)
			report($sformatf("%s got %0h want %0h", name, got, exp));
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin : req_driver
		if (!arst_n) begin
			req_if.valid <= 1'b0;
			req_gap      <= 0;
		end else begin
			if (req_if.valid && req_if.ready) begin
				compute_drive_words(req_if.payload);
				req_taken++;
			end
			if (!req_if.valid || req_if.ready) begin
				if (req_gap != 0) begin
					req_if.valid <= 1'b0;
					req_gap      <= req_gap - 1;
				end else if (req_words_q.size() != 0) begin
					req_if.payload <= req_words_q.pop_front();
					req_if.valid   <= 1'b1;
					req_gap        <= draw_idle();
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	// drive word monitor and checker
	always @(posedge clk or negedge arst_n) begin : drive_monitor
		drive_t got;
		drive_t exp_w;
		int     stall;
		if (!arst_n) begin
			drive_if.ready <= 1'b0;
			drive_stall    <= 0;
		end else begin
			stall = drive_stall;
			if (drive_if.valid && drive_if.ready) begin
				got = drive_if.payload;
				if (drive_words_q.size() == 0) begin
					report($sformatf("unexpected drive word for channel %0d", got.channel));
				end else begin
					exp_w = drive_words_q.pop_front();
					check_field("channel", 8'(got.channel), 8'(exp_w.channel));
					check_field("drive_on", 8'(got.drive_on), 8'(exp_w.drive_on));
					check_field("out_left_low", got.out_left_low, exp_w.out_left_low);
					check_field("out_left_high", got.out_left_high, exp_w.out_left_high);
					check_field("out_right_low", got.out_right_low, exp_w.out_right_low);
					check_field("out_right_high", got.out_right_high, exp_w.out_right_high);
					check_field("last_of_tick", 8'(got.last_of_tick), 8'(exp_w.last_of_tick));
				end
				stall = draw_idle();
			end
			if (stall != 0) begin
				drive_if.ready <= 1'b0;
				drive_stall    <= stall - 1;
			end else begin
				drive_if.ready <= 1'b1;
				drive_stall    <= 0;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin : stimulus
		arst_n         = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		req_if.valid   = 1'b0;
		req_if.payload = '0;
		drive_if.ready = 1'b0;
		en_reg         = 1'b1;
		pct_reg        = FULL_PERCENT;
		for (int ch = 0; ch < NCH; ch++) begin
			ch_amp[ch]    = '0;
			ch_on_ms[ch]  = '0;
			ch_off_ms[ch] = '0;
			ch_repeat[ch] = '0;
			ch_pos[ch]    = 0;
			ch_done[ch]   = 0;
			ch_active[ch] = 1'b0;
			ch_lit[ch]    = 1'b0;
			ch_dirty[ch]  = 1'b0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: idle tick, full and zero amplitudes, default on time,
		// out of range pads, longest timers, reload of a lit channel
		push_ticks(1);
		push_item(make_cmd(3'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'd0, 16'd0, 8'd0));
		push_ticks(1);
		push_item(make_cmd(3'd1, 8'h00, 8'h00, 8'h00, 8'h00, 16'd5, 16'd5, 8'd3));
		push_item(make_cmd(3'd3, 8'h01, 8'h80, 8'h00, 8'h7F, 16'd2, 16'd1, 8'd1));
		push_item(make_cmd(3'd7, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF));
		push_item(make_cmd(3'd4, 8'h01, 8'h02, 8'h03, 8'h04, 16'd1, 16'd1, 8'd1));
		push_item(make_cmd(3'd2, 8'h55, 8'hAA, 8'h01, 8'h80, 16'hFFFF, 16'hFFFF, 8'hFF));
		push_ticks(8);
		push_item(make_cmd(3'd0, 8'd10, 8'd20, 8'd30, 8'd40, 16'd1, 16'd0, 8'd0));
		push_item(make_cmd(3'd2, 8'hC8, 8'h00, 8'h00, 8'h00, 16'd0, 16'd0, 8'hFF));
		push_ticks(6);
		settle();

		reg_write(REG_STRENGTH, 32'd50);
		push_random(40);
		settle();

		// disabled: lit channels turn off, commands stay inactive
		reg_write(REG_ENABLE, 32'd0);
		push_random(20);
		settle();

		reg_write(REG_ENABLE, 32'd1);
		reg_write(REG_STRENGTH, 32'd0);
		push_random(20);
		settle();

		// above full scale acts as full scale
		reg_write(REG_STRENGTH, 32'd127);
		push_random(40);
		settle();

		// disable and re-enable between ticks still turns lit channels off
		reg_write(REG_ENABLE, 32'd0);
		reg_write(REG_ENABLE, 32'd1);
		reg_write(REG_STRENGTH, 32'(FULL_PERCENT));
		push_random(40);
		settle();

		if (err_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
